### hw/rtl/gpsc_pkg.sv
package gpsc_pkg;

  localparam int unsigned DepthBitsDefault = 8;

  localparam logic [7:0] SepReset  = 8'd47;

  localparam logic [7:0] ChBsl     = 8'd92;
  localparam logic [7:0] ChLbrk    = 8'd91;
  localparam logic [7:0] ChBang    = 8'd33;
  localparam logic [7:0] ChCaret   = 8'd94;
  localparam logic [7:0] ChRbrk    = 8'd93;
  localparam logic [7:0] ChLbrc    = 8'd123;
  localparam logic [7:0] ChRbrc    = 8'd125;

  typedef enum logic [5:0] {
    PhNormal  = 6'b000001,
    PhEscOut  = 6'b000010,
    PhClsOpen = 6'b000100,
    PhClsNeg  = 6'b001000,
    PhClsBody = 6'b010000,
    PhClsEsc  = 6'b100000
  } phase_e;

  typedef struct packed {
    logic       valid;
    logic [7:0] pattern_byte;
    logic       end_of_pattern;
  } in_req_t;

endpackage

### hw/rtl/glob_pattern_syntax_check_unit.sv
// glob pattern syntax checker
// input channel: one pattern byte per request (pattern_byte_i), with
//   end_of_pattern_i set on the final byte; in_valid_i / in_stall_o
// output channel: one verdict per pattern (pattern_valid_o), out_valid_o /
//   out_stall_i; bytes other than the last produce no output request
// config channel: cfg_valid_i / cfg_ready_o with the path separator byte;
//   always ready, write only while no pattern byte is in flight
// throughput: one byte per cycle while no final byte waits on a stalled
//   output; the phase and brace depth update lies between the input register
//   and the verdict register, which registers and presents the verdict of
//   the last byte
// reset: separator returns to '/', scan state and depth clear, both
//   channels empty
// when the receiver stalls, the verdict holds; further non-final bytes keep
//   flowing, and a second final byte waits in the input register, which
//   then stalls the sender
module glob_pattern_syntax_check_unit #(
  parameter int unsigned DepthBits = gpsc_pkg::DepthBitsDefault
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] pattern_byte_i,
  input  logic       end_of_pattern_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic       pattern_valid_o,
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic [7:0] cfg_path_separator_i
);

  gpsc_pkg::in_req_t req;
  logic              advance;
  logic              out_free;
  logic              verdict;
  logic [7:0]        sep_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sep_q <= gpsc_pkg::SepReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      sep_q <= cfg_path_separator_i;
    end
  end

  assign advance = req.valid && (out_free || !req.end_of_pattern);

  gpsc_in_reg u_in_reg (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .pattern_byte_i   (pattern_byte_i),
    .end_of_pattern_i (end_of_pattern_i),
    .advance_i        (advance),
    .in_stall_o       (in_stall_o),
    .req_o            (req)
  );

  gpsc_scanner #(
    .DepthBits (DepthBits)
  ) u_scanner (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .advance_i (advance),
    .req_i     (req),
    .sep_i     (sep_q),
    .verdict_o (verdict)
  );

  gpsc_out_reg u_out_reg (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .load_i          (advance && req.end_of_pattern),
    .verdict_i       (verdict),
    .out_stall_i     (out_stall_i),
    .free_o          (out_free),
    .out_valid_o     (out_valid_o),
    .pattern_valid_o (pattern_valid_o)
  );

endmodule

### hw/rtl/gpsc_in_reg.sv
module gpsc_in_reg (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  input  logic [7:0]       pattern_byte_i,
  input  logic             end_of_pattern_i,
  input  logic             advance_i,
  output logic             in_stall_o,
  output gpsc_pkg::in_req_t req_o
);

  logic       valid_q, valid_d;
  logic [7:0] byte_q;
  logic       last_q;
  logic       take;

  assign in_stall_o = valid_q && !advance_i;
  assign take       = in_valid_i && !in_stall_o;

  always_comb begin
    valid_d = valid_q;
    if (take) begin
      valid_d = 1'b1;
    end else if (advance_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      byte_q <= pattern_byte_i;
      last_q <= end_of_pattern_i;
    end
  end

  assign req_o.valid          = valid_q;
  assign req_o.pattern_byte   = byte_q;
  assign req_o.end_of_pattern = last_q;

endmodule

### hw/rtl/gpsc_scanner.sv
module gpsc_scanner #(
  parameter int unsigned DepthBits = gpsc_pkg::DepthBitsDefault
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             advance_i,
  input  gpsc_pkg::in_req_t req_i,
  input  logic [7:0]       sep_i,
  output logic             verdict_o
);

  gpsc_pkg::phase_e       phase_q, phase_d, phase_n;
  logic [DepthBits-1:0]   depth_q, depth_d, depth_n;
  logic                   fail_q, fail_d, fail_n;
  logic [7:0]             b;
  logic                   sep_bsl;
  gpsc_pkg::phase_e       body_phase;

  assign b       = req_i.pattern_byte;
  assign sep_bsl = (sep_i == gpsc_pkg::ChBsl);

  // next phase for a byte inside a class body
  always_comb begin
    if (!sep_bsl && b == gpsc_pkg::ChBsl) begin
      body_phase = gpsc_pkg::PhClsEsc;
    end else if (b == gpsc_pkg::ChRbrk) begin
      body_phase = gpsc_pkg::PhNormal;
    end else begin
      body_phase = gpsc_pkg::PhClsBody;
    end
  end

  always_comb begin
    phase_n = phase_q;
    depth_n = depth_q;
    fail_n  = fail_q;
    case (phase_q)
      gpsc_pkg::PhEscOut: begin
        phase_n = gpsc_pkg::PhNormal;
      end
      gpsc_pkg::PhClsOpen: begin
        if (b == gpsc_pkg::ChBang || b == gpsc_pkg::ChCaret) begin
          phase_n = gpsc_pkg::PhClsNeg;
        end else if (b == gpsc_pkg::ChRbrk) begin
          fail_n  = 1'b1;
          phase_n = gpsc_pkg::PhNormal;
        end else begin
          phase_n = body_phase;
        end
      end
      gpsc_pkg::PhClsNeg: begin
        if (b == gpsc_pkg::ChRbrk) begin
          fail_n  = 1'b1;
          phase_n = gpsc_pkg::PhNormal;
        end else begin
          phase_n = body_phase;
        end
      end
      gpsc_pkg::PhClsBody: begin
        phase_n = body_phase;
      end
      gpsc_pkg::PhClsEsc: begin
        phase_n = gpsc_pkg::PhClsBody;
      end
      default: begin
        phase_n = gpsc_pkg::PhNormal;
        if (b == gpsc_pkg::ChBsl) begin
          if (sep_bsl) begin
            phase_n = gpsc_pkg::PhEscOut;
          end
        end else if (b == gpsc_pkg::ChLbrk) begin
          phase_n = gpsc_pkg::PhClsOpen;
        end else if (b == gpsc_pkg::ChLbrc) begin
          if (depth_q == {DepthBits{1'b1}}) begin
            fail_n = 1'b1;
          end else begin
            depth_n = depth_q + 1'b1;
          end
        end else if (b == gpsc_pkg::ChRbrc) begin
          if (depth_q == '0) begin
            fail_n = 1'b1;
          end else begin
            depth_n = depth_q - 1'b1;
          end
        end
      end
    endcase
  end

  assign verdict_o = !fail_n && (phase_n == gpsc_pkg::PhNormal) && (depth_n == '0);

  always_comb begin
    phase_d = phase_q;
    depth_d = depth_q;
    fail_d  = fail_q;
    if (advance_i) begin
      if (req_i.end_of_pattern) begin
        phase_d = gpsc_pkg::PhNormal;
        depth_d = '0;
        fail_d  = 1'b0;
      end else begin
        phase_d = phase_n;
        depth_d = depth_n;
        fail_d  = fail_n;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= gpsc_pkg::PhNormal;
      depth_q <= '0;
      fail_q  <= 1'b0;
    end else begin
      phase_q <= phase_d;
      depth_q <= depth_d;
      fail_q  <= fail_d;
    end
  end

endmodule

### hw/rtl/gpsc_out_reg.sv
module gpsc_out_reg (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic load_i,
  input  logic verdict_i,
  input  logic out_stall_i,
  output logic free_o,
  output logic out_valid_o,
  output logic pattern_valid_o
);

  logic valid_q, valid_d;
  logic verdict_q;

  assign free_o = !valid_q || !out_stall_i;

  always_comb begin
    valid_d = valid_q;
    if (load_i) begin
      valid_d = 1'b1;
    end else if (!out_stall_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      verdict_q <= verdict_i;
    end
  end

  assign out_valid_o     = valid_q;
  assign pattern_valid_o = verdict_q;

endmodule
